FILE: sv/ccsc_pkg.sv
// Package for the CRC codeword stream checker.
// Holds widths, register indexes and the structs shared by the modules.
// No dependencies.
`default_nettype none

package ccsc_pkg;

  // Longest generator, leading one included.
  localparam int unsigned MaxGenBits = 17;
  // Remainder width is one less than the generator length.
  localparam int unsigned RemW       = MaxGenBits - 1;
  localparam int unsigned GenLenW    = 5;
  localparam int unsigned CountW     = 32;
  // Dataword bits waiting for a byte: at most 4 carried plus 8 added.
  localparam int unsigned AccW       = 12;
  localparam int unsigned AccCntW    = 4;
  localparam int unsigned PosW       = 5;
  localparam int unsigned DataW      = 8;
  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 32;

  // Register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    RegGenPoly  = 2'd0,
    RegGenLen   = 2'd1,
    RegWideData = 2'd2,
    RegUnused   = 2'd3
  } reg_idx_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [MaxGenBits-1:0] generator_poly;
    logic [GenLenW-1:0]    generator_length;
    logic                  wide_dataword;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic [DataW-1:0]  out_byte;
    logic              byte_valid;
    logic              done_res;
    logic [CountW-1:0] codeword_count;
    logic [CountW-1:0] error_count;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/ccsc_if.sv
// Stream channel interfaces for the CRC codeword stream checker.
// Depends on ccsc_pkg for the field widths.
`default_nettype none

interface ccsc_in_if;
  import ccsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_byte;
  logic             last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ccsc_out_if;
  import ccsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  out_byte;
  logic              byte_valid;
  logic              done_res;
  logic [CountW-1:0] codeword_count;
  logic [CountW-1:0] error_count;

  modport source (output valid, output out_byte, output byte_valid, output done_res,
                  output codeword_count, output error_count, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                  input codeword_count, input error_count, output ready);
endinterface

`default_nettype wire

FILE: sv/crc_codeword_stream_checker_top.sv
// Top level of the CRC codeword stream checker: registers, datapath, result queue.
// Depends on ccsc_pkg, ccsc_if, ccsc_regs and ccsc_core.
//
//   channel  | dir | payload                                        | beat
//   in_ch    | in  | data_byte, last_byte                           | one stream byte
//   out_ch   | out | out_byte, byte_valid, done_res, codeword_count,| one result
//            |     | error_count                                    |
//   APB      | in  | generator_poly, generator_length, wide_dataword| one register
//
// One input beat per cycle while in_ch.ready is high; the eight bit steps of the
// remainder register run in the cycle the byte is accepted, and the result is
// registered in a two-entry result queue on the output; in_ch.ready drops only while
// both entries are full. Reset puts the stream back to await its pad count
// byte and loads the register defaults.
`default_nettype none

module crc_codeword_stream_checker_top
  import ccsc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ccsc_in_if.sink                  in_ch,
  ccsc_out_if.source               out_ch,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output      logic [ApbDataW-1:0] prdata,
  output      logic                pready
);

  cfg_t       cfg;
  logic       in_acc;
  logic       res_valid;
  result_t    res;
  result_t    ent0_q, ent1_q;
  logic [1:0] count_q;
  logic       push;
  logic       pop;
  logic       push_head;

  ccsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ccsc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .accept_i    (in_acc),
    .data_byte_i (in_ch.data_byte),
    .last_byte_i (in_ch.last_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_ch.ready = (count_q != 2'd2);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign push        = in_acc & res_valid;
  assign pop         = out_ch.valid & out_ch.ready;
  // A new result lands at the head when the queue is, or is about to be, empty.
  assign push_head   = push & ((count_q == 2'd0) | ((count_q == 2'd1) & pop));

  // Result queue occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (push && !pop) begin
      count_q <= count_q + 2'd1;
    end else if (pop && !push) begin
      count_q <= count_q - 2'd1;
    end
  end

  // Result queue entries; entry 0 is the head shown on out_ch.
  always_ff @(posedge clk_i) begin
    if (push_head) begin
      ent0_q <= res;
    end else if (pop) begin
      ent0_q <= ent1_q;
    end
    if (push && !push_head) begin
      ent1_q <= res;
    end
  end

  assign out_ch.valid          = (count_q != 2'd0);
  assign out_ch.out_byte       = ent0_q.out_byte;
  assign out_ch.byte_valid     = ent0_q.byte_valid;
  assign out_ch.done_res       = ent0_q.done_res;
  assign out_ch.codeword_count = ent0_q.codeword_count;
  assign out_ch.error_count    = ent0_q.error_count;

  // The queue never holds more than two results.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("result queue overflow");

  // Every shown result carries a byte or marks the end of a stream.
  a_res_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.byte_valid || out_ch.done_res))
    else $error("empty result in queue");

  // Counts are zero on results that do not close a stream.
  a_counts_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.done_res) |->
      (out_ch.codeword_count == '0 && out_ch.error_count == '0))
    else $error("counts shown before end of stream");

  // A byte field without a byte reads as zero.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.byte_valid) |-> (out_ch.out_byte == '0))
    else $error("stray output byte");

  // A result pushed into an empty queue is shown in the next cycle.
  a_push_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && count_q == 2'd0) |=> out_ch.valid)
    else $error("result lost on push");

endmodule

`default_nettype wire

FILE: sv/ccsc_regs.sv
// APB-style configuration registers of the CRC codeword stream checker.
// Depends on ccsc_pkg for register indexes and the cfg_t struct.
`default_nettype none

module ccsc_regs
  import ccsc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output      logic [ApbDataW-1:0] prdata,
  output      logic                pready,
  output      cfg_t                cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // Register writes in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.generator_poly   <= MaxGenBits'(7);
      cfg_q.generator_length <= GenLenW'(3);
      cfg_q.wide_dataword    <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        RegGenPoly:  cfg_q.generator_poly   <= pwdata[MaxGenBits-1:0];
        RegGenLen:   cfg_q.generator_length <= pwdata[GenLenW-1:0];
        RegWideData: cfg_q.wide_dataword    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      RegGenPoly:  prdata = ApbDataW'(cfg_q.generator_poly);
      RegGenLen:   prdata = ApbDataW'(cfg_q.generator_length);
      RegWideData: prdata = ApbDataW'(cfg_q.wide_dataword);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: sv/ccsc_core.sv
// Stream state and byte datapath of the CRC codeword stream checker.
// Eight unrolled bit steps of the remainder shift register per accepted byte.
// Depends on ccsc_pkg for widths and the cfg_t and result_t structs.
`default_nettype none

module ccsc_core
  import ccsc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             accept_i,
  input  wire logic [DataW-1:0] data_byte_i,
  input  wire logic             last_byte_i,
  output      logic             res_valid_o,
  output      result_t          res_o
);

  // Stream state.
  logic               header_q, header_d;
  logic [DataW-1:0]   skip_q, skip_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [DataW-1:0]   cwd_q, cwd_d;
  logic [DataW-1:0]   shift_q, shift_d;
  logic [AccCntW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0]  seen_q, seen_d;
  logic [CountW-1:0]  bad_q, bad_d;

  // Clamped generator length and the values derived from it.
  logic [GenLenW-1:0] g;
  logic [3:0]         d;
  logic [PosW-1:0]    cw_len;
  logic [RemW-1:0]    rmask;
  logic [RemW-1:0]    taps;
  logic [3:0]         top_idx;
  logic [DataW-1:0]   dmask;

  always_comb begin
    if (cfg_i.generator_length < GenLenW'(2)) begin
      g = GenLenW'(2);
    end else if (cfg_i.generator_length > GenLenW'(MaxGenBits)) begin
      g = GenLenW'(MaxGenBits);
    end else begin
      g = cfg_i.generator_length;
    end
    d       = cfg_i.wide_dataword ? 4'd8 : 4'd4;
    dmask   = cfg_i.wide_dataword ? 8'hFF : 8'h0F;
    cw_len  = PosW'(d) + PosW'(g) - PosW'(1);
    top_idx = 4'(g - GenLenW'(2));
    for (int k = 0; k < RemW; k++) begin
      rmask[k] = (GenLenW'(k) < (g - GenLenW'(1)));
    end
    taps = cfg_i.generator_poly[RemW-1:0] & rmask;
  end

  // Next stream state and result for the byte on the input.
  always_comb begin : step
    logic [RemW-1:0]    rem;
    logic [RemW-1:0]    rem_sh;
    logic [PosW-1:0]    pos;
    logic [DataW-1:0]   cwd;
    logic [DataW-1:0]   skip;
    logic [AccW-1:0]    acc;
    logic [AccCntW-1:0] cnt;
    logic [1:0]         n_seen;
    logic [1:0]         n_bad;
    logic               top;
    logic               bit_in;
    logic               valid;
    logic [DataW-1:0]   obyte;
    logic [CountW:0]    seen_sum;
    logic [CountW:0]    bad_sum;

    rem    = rem_q;
    pos    = pos_q;
    cwd    = cwd_q;
    skip   = skip_q;
    acc    = AccW'(shift_q);
    cnt    = cnt_q;
    n_seen = 2'd0;
    n_bad  = 2'd0;
    top    = 1'b0;
    bit_in = 1'b0;
    rem_sh = '0;
    valid  = 1'b0;
    obyte  = '0;

    // Bit steps, most significant bit first.
    for (int i = DataW - 1; i >= 0; i--) begin
      bit_in = data_byte_i[i];
      if (skip != '0) begin
        skip = skip - DataW'(1);
      end else begin
        top    = rem[top_idx];
        rem_sh = {rem[RemW-2:0], bit_in} & rmask;
        if (top) begin
          rem_sh = rem_sh ^ taps;
        end
        rem = rem_sh;
        if (PosW'(d) > pos) begin
          cwd = {cwd[DataW-2:0], bit_in};
        end
        if (({1'b0, pos} + (PosW+1)'(1)) >= {1'b0, cw_len}) begin
          n_seen = n_seen + 2'd1;
          if (rem != '0) begin
            n_bad = n_bad + 2'd1;
          end
          acc = (acc << d) | AccW'(cwd & dmask);
          cnt = cnt + AccCntW'(d);
          rem = '0;
          pos = '0;
          cwd = '0;
        end else begin
          pos = pos + PosW'(1);
        end
      end
    end

    // Hand out a byte once eight dataword bits have gathered.
    if (cnt >= AccCntW'(8)) begin
      valid = 1'b1;
      obyte = DataW'(acc >> (cnt - AccCntW'(8)));
      cnt   = cnt - AccCntW'(8);
      acc   = acc & ((AccW'(1) << cnt) - AccW'(1));
    end

    // Saturating codeword and error counters.
    seen_sum = {1'b0, seen_q} + (CountW+1)'(n_seen);
    bad_sum  = {1'b0, bad_q} + (CountW+1)'(n_bad);

    header_d = header_q;
    skip_d   = skip_q;
    rem_d    = rem_q;
    pos_d    = pos_q;
    cwd_d    = cwd_q;
    shift_d  = shift_q;
    cnt_d    = cnt_q;
    seen_d   = seen_q;
    bad_d    = bad_q;
    res_o    = '0;

    if (header_q) begin
      // The first byte of a stream only loads the pad count.
      header_d = 1'b0;
      skip_d   = data_byte_i;
    end else begin
      skip_d  = skip;
      rem_d   = rem;
      pos_d   = pos;
      cwd_d   = cwd;
      shift_d = acc[DataW-1:0];
      cnt_d   = cnt;
      seen_d  = seen_sum[CountW] ? '1 : seen_sum[CountW-1:0];
      bad_d   = bad_sum[CountW] ? '1 : bad_sum[CountW-1:0];
      res_o.out_byte   = obyte;
      res_o.byte_valid = valid;
    end

    res_valid_o = res_o.byte_valid | last_byte_i;

    if (last_byte_i) begin
      res_o.done_res       = 1'b1;
      res_o.codeword_count = seen_d;
      res_o.error_count    = bad_d;
      // End of stream: back to the reset state, registers kept.
      header_d = 1'b1;
      skip_d   = '0;
      rem_d    = '0;
      pos_d    = '0;
      cwd_d    = '0;
      shift_d  = '0;
      cnt_d    = '0;
      seen_d   = '0;
      bad_d    = '0;
    end
  end

  // State registers, updated on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= 1'b1;
      skip_q   <= '0;
      rem_q    <= '0;
      pos_q    <= '0;
      cwd_q    <= '0;
      shift_q  <= '0;
      cnt_q    <= '0;
      seen_q   <= '0;
      bad_q    <= '0;
    end else if (accept_i) begin
      header_q <= header_d;
      skip_q   <= skip_d;
      rem_q    <= rem_d;
      pos_q    <= pos_d;
      cwd_q    <= cwd_d;
      shift_q  <= shift_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      bad_q    <= bad_d;
    end
  end

endmodule

`default_nettype wire
